// File: rtl/core/tefh_pkg.sv
// Package: shared types, constants and SHA-256 helpers for the extension fingerprint hash.
package tefh_pkg;

	localparam logic [1:0] REQ_EXT    = 2'd0;
	localparam logic [1:0] REQ_BODY   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} out_item_t;

	// Classified work for the back part: an optional separator, an optional code, or finish.
	typedef struct packed {
		logic        finish;
		logic        has_code;
		logic        has_sep;
		logic [7:0]  sep;
		logic [15:0] code;
	} work_t;

	typedef logic [31:0] word_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
		else r = 8'h57 + {4'd0, nib};
		return r;
	endfunction

	function automatic logic is_grease(input logic [15:0] c);
		return (c[11:8] == 4'hA) && (c[3:0] == 4'hA) && (c[15:12] == c[7:4]);
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// File: rtl/core/tefh_front.sv
// Front part: accepts items, tracks body parsing and classifies each item into work.
module tefh_front import tefh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     wk_valid,
	input  logic     wk_ready,
	output work_t    wk_item
);

	logic        ext_seen_q;
	logic        algs_q;
	logic [16:0] idx_q;
	logic [16:0] end_q;
	logic [7:0]  held_q;
	logic        fin_pend_q;   // finish sent, hold the front until the queue has room
	logic        acc;
	logic [15:0] alg;
	logic        keep_alg;

	// Finish resets the front too; the next item waits while fin_pend_q is set, which clears once the queue has room.
	assign in_ready = wk_ready && !fin_pend_q;
	assign acc      = in_valid && in_ready;
	assign alg      = {held_q, in_item.item_value[7:0]};
	assign keep_alg = (idx_q != 17'd1) && idx_q[0] && (idx_q < end_q) && !is_grease(alg);

	always_comb begin
		wk_item          = '0;
		wk_item.code     = in_item.item_value;
		wk_valid         = 1'b0;
		unique case (in_item.req_type)
			REQ_EXT: begin
				wk_valid         = acc;
				wk_item.has_code = 1'b1;
				wk_item.has_sep  = ext_seen_q;
				wk_item.sep      = 8'h2c;
			end
			REQ_BODY: begin
				wk_valid         = acc && keep_alg;
				wk_item.code     = alg;
				wk_item.has_code = 1'b1;
				wk_item.has_sep  = 1'b1;
				wk_item.sep      = algs_q ? 8'h2c : 8'h5f;
			end
			REQ_FINISH: begin
				wk_valid       = acc;
				wk_item.finish = 1'b1;
			end
			default: wk_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_seen_q <= 1'b0;
			algs_q     <= 1'b0;
			idx_q      <= '0;
			end_q      <= '0;
			held_q     <= '0;
			fin_pend_q <= 1'b0;
		end else begin
			if (fin_pend_q && wk_ready) fin_pend_q <= 1'b0;
			if (acc) begin
				unique case (in_item.req_type)
					REQ_EXT: ext_seen_q <= 1'b1;
					REQ_BODY: begin
						if (idx_q == 17'd1)
							end_q <= 17'd2 + {1'b0, held_q, in_item.item_value[7:0]};
						else if (!idx_q[0])
							held_q <= in_item.item_value[7:0];
						else if (keep_alg)
							algs_q <= 1'b1;
						if (idx_q != 17'h1FFFF) idx_q <= idx_q + 17'd1;
					end
					REQ_FINISH: begin
						ext_seen_q <= 1'b0;
						algs_q     <= 1'b0;
						idx_q      <= '0;
						end_q      <= '0;
						held_q     <= '0;
						fin_pend_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/core/tefh_queue.sv
// Short work queue between the front and back parts.
module tefh_queue import tefh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  work_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output work_t rd_item
);

	localparam int AW = $clog2(QueueDepth);

	work_t         mem_q [QueueDepth];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          wr;
	logic          rd;

	assign wr_ready = (cnt_q != QueueDepth[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
		end
	end

endmodule

// File: rtl/core/tefh_sha_core.sv
// SHA-256 compression: one round a cycle over a 16-word schedule window.
module tefh_sha_core import tefh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] block,
	input  word_t        h_in [8],
	output logic         done,
	output word_t        h_out [8]
);

	word_t      w_q [16];
	word_t      v_q [8];
	logic [5:0] rnd_q;
	logic       run_q;
	word_t      s0, s1, wn, e1, ch, t1, a0, mj;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + RoundK[rnd_q] + w_q[0];
		a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_in[i] + v_q[i];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_in[i];
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + a0 + mj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/tefh_back.sv
// Back part: writes characters and padding into the block, runs compression, emits digest.
module tefh_back import tefh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wk_valid,
	output logic      wk_ready,
	input  work_t     wk_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHARS, ST_HASH, ST_PAD, ST_LEN, ST_EMIT
	} state_t;

	state_t       st_q;
	state_t       ret_q;     // where to go after a compression
	logic [511:0] blk_q;     // byte 0 in the top eight bits
	logic [63:0]  nbytes_q;
	logic         any_q;
	word_t        cv_q [8];
	work_t        cur_q;
	logic [2:0]   ch_q;      // 0 separator, 1..4 hex nibbles
	logic [1:0]   oi_q;
	logic [63:0]  bits_q;
	logic [2:0]   li_q;
	logic         mark_q;    // next padding byte is the 0x80 marker
	logic         start;
	logic         start_q;   // core loads the block once its last byte is in
	logic         done;
	word_t        h_out [8];
	logic [7:0]   byte_d;
	logic [3:0]   nib;

	tefh_sha_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.block (blk_q),
		.h_in  (cv_q),
		.done  (done),
		.h_out (h_out)
	);

	always_comb begin
		unique case (ch_q)
			3'd1: nib = cur_q.code[15:12];
			3'd2: nib = cur_q.code[11:8];
			3'd3: nib = cur_q.code[7:4];
			default: nib = cur_q.code[3:0];
		endcase
		byte_d = (ch_q == 3'd0) ? cur_q.sep : hex_char(nib);
	end

	assign wk_ready  = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_EMIT);
	assign out_item.digest_word = any_q ? {cv_q[{oi_q, 1'b0}], cv_q[{oi_q, 1'b1}]} : 64'd0;
	assign out_item.last_word   = (oi_q == 2'd3);

	// a byte written now fills the block when the low six count bits are all ones
	logic full;
	assign full  = (nbytes_q[5:0] == 6'd63);
	assign start = (st_q inside {ST_CHARS, ST_PAD, ST_LEN}) && full &&
		!((st_q == ST_CHARS) && (ch_q == 3'd0) && !cur_q.has_sep);

	always_ff @(posedge clk) begin
		if (st_q == ST_CHARS && !(ch_q == 3'd0 && !cur_q.has_sep))
			blk_q[{~nbytes_q[5:0], 3'b000} +: 8] <= byte_d;
		else if (st_q == ST_PAD)
			blk_q[{~nbytes_q[5:0], 3'b000} +: 8] <= mark_q ? 8'h80 : 8'h00;
		else if (st_q == ST_LEN)
			blk_q[{~nbytes_q[5:0], 3'b000} +: 8] <= bits_q[63 - 8*li_q -: 8];
		if (wk_valid && wk_ready) cur_q <= wk_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ret_q    <= ST_IDLE;
			nbytes_q <= '0;
			any_q    <= 1'b0;
			ch_q     <= '0;
			oi_q     <= '0;
			bits_q   <= '0;
			li_q     <= '0;
			mark_q   <= 1'b0;
			start_q  <= 1'b0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
		end else begin
			start_q <= start;
			unique case (st_q)
				ST_IDLE: begin
					if (wk_valid) begin
						ch_q <= 3'd0;
						oi_q <= 2'd0;
						li_q <= 3'd0;
						if (wk_item.finish) begin
							bits_q <= {nbytes_q[60:0], 3'b000};   // message length in bits
							mark_q <= 1'b1;
							st_q   <= any_q ? ST_PAD : ST_EMIT;
						end else begin
							st_q   <= ST_CHARS;
							any_q  <= 1'b1;
						end
					end
				end
				ST_CHARS: begin
					if (!(ch_q == 3'd0 && !cur_q.has_sep)) nbytes_q <= nbytes_q + 64'd1;
					ch_q <= ch_q + 3'd1;
					if (start) begin
						st_q  <= ST_HASH;
						ret_q <= (ch_q == 3'd4) ? ST_IDLE : ST_CHARS;
					end else if (ch_q == 3'd4) st_q <= ST_IDLE;
				end
				ST_PAD: begin
					nbytes_q <= nbytes_q + 64'd1;
					mark_q   <= 1'b0;
					if (start) begin
						st_q  <= ST_HASH;
						ret_q <= ST_PAD;
					end else if (nbytes_q[5:0] == 6'd55) st_q <= ST_LEN;
				end
				ST_LEN: begin
					nbytes_q <= nbytes_q + 64'd1;
					li_q     <= li_q + 3'd1;
					if (li_q == 3'd7) begin
						st_q  <= ST_HASH;
						ret_q <= ST_EMIT;
					end
				end
				ST_HASH: begin
					if (done) begin
						for (int i = 0; i < 8; i++) cv_q[i] <= h_out[i];
						// after a padding block, more padding until position 56
						if (ret_q == ST_PAD && nbytes_q[5:0] == 6'd56) st_q <= ST_LEN;
						else st_q <= ret_q;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						oi_q <= oi_q + 2'd1;
						if (oi_q == 2'd3) begin
							st_q     <= ST_IDLE;
							nbytes_q <= '0;
							any_q    <= 1'b0;
							for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/tls_extension_fingerprint_hash.sv
// Top level: extension fingerprint hash, front classifier, work queue and SHA-256 back part.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------
//  input     | in_valid / in_ready   | in_item  (req_type, item_value)
//  output    | out_valid / out_ready | out_item (digest_word, last_word)
//
// An extension code or kept algorithm takes a back-part step to leave the queue, a separator
// slot and four hex characters, plus a compression whenever a 64-byte block fills and the
// single-round SHA-256 core runs (load, 64 rounds, fold into the chain value); finish adds
// padding and one or two compressions if items came, then four result items (zero if none).
// The front takes one item a cycle while the queue has room; a finish holds the front for
// the cycle after it, longer while the queue is full. Reset returns the chain value to the
// SHA-256 initial words.
module tls_extension_fingerprint_hash import tefh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic  fq_valid, fq_ready, qb_valid, qb_ready;
	work_t fq_item, qb_item;

	tefh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.wk_valid(fq_valid), .wk_ready(fq_ready), .wk_item(fq_item)
	);

	tefh_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
	);

	tefh_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wk_valid(qb_valid), .wk_ready(qb_ready), .wk_item(qb_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule
